### src/spline_table_pair_energy_force_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tabulated pair energy and force block
// Shared helpers for concurrent checks; each expands to one labeled assert.
// ---------------------------------------------------------------------------
`ifndef SPLINE_TABLE_PAIR_ENERGY_FORCE_DEFINES_SVH
`define SPLINE_TABLE_PAIR_ENERGY_FORCE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define STPEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define STPEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/stpef_pkg.sv
// ---------------------------------------------------------------------------
// stpef_pkg
// Types, codes and saturation helpers for the spline pair energy block.
// ---------------------------------------------------------------------------
package stpef_pkg;

    localparam int NUM_TYPES_DEF = 4;
    localparam int NUM_KNOTS_DEF = 256;

    localparam int APB_AW = 4;

    // register indexes
    localparam logic [1:0] REG_CUTOFF    = 2'd0;
    localparam logic [1:0] REG_KNOT_SP   = 2'd1;
    localparam logic [1:0] REG_INV_KNOT  = 2'd2;

    localparam logic [30:0] CUTOFF_RST   = 31'd655360;
    localparam logic [30:0] KNOT_SP_RST  = 31'd2560;
    localparam logic [30:0] INV_KNOT_RST = 31'd1677722;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_EVAL  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    // report the totals only
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // 0.0001 in Q16.16
    localparam logic signed [31:0] SMALL_Q = 32'sd7;

    // multiplier operand selects
    localparam logic [3:0] M_NONE = 4'd0;
    localparam logic [3:0] M_DINV = 4'd1;
    localparam logic [3:0] M_KS   = 4'd2;
    localparam logic [3:0] M_QQ   = 4'd3;
    localparam logic [3:0] M_HORN = 4'd4;
    localparam logic [3:0] M_EE   = 4'd5;
    localparam logic [3:0] M_CC   = 4'd6;
    localparam logic [3:0] M_FX   = 4'd7;
    localparam logic [3:0] M_FY   = 4'd8;
    localparam logic [3:0] M_FZ   = 4'd9;

    // uses of the registered product
    localparam logic [3:0] P_NONE = 4'd0;
    localparam logic [3:0] P_R    = 4'd1;
    localparam logic [3:0] P_DIF  = 4'd2;
    localparam logic [3:0] P_QQ   = 4'd3;
    localparam logic [3:0] P_HORN = 4'd4;
    localparam logic [3:0] P_EE   = 4'd5;
    localparam logic [3:0] P_CC   = 4'd6;
    localparam logic [3:0] P_FX   = 4'd7;
    localparam logic [3:0] P_FY   = 4'd8;
    localparam logic [3:0] P_FZ   = 4'd9;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         type_i;
        logic [1:0]         type_j;
        logic [30:0]        dist_req;
        logic signed [31:0] charge_i;
        logic signed [31:0] charge_j;
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
        logic               partner_local;
        logic [31:0]        owner_id;
        logic [31:0]        partner_id;
    } stpef_in_t;

    typedef struct packed {
        logic               pair_kept;
        logic signed [31:0] vdw_energy;
        logic signed [31:0] ele_energy;
        logic signed [31:0] force_scale;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [47:0] total_vdw;
        logic signed [47:0] total_ele;
    } stpef_out_t;

    typedef struct packed {
        logic [30:0] cutoff;
        logic [30:0] knot_spacing;
        logic [30:0] inv_knot_spacing;
    } stpef_cfg_t;

    typedef struct packed {
        logic       latch;
        logic       set_kept;
        logic [3:0] mul_sel;
        logic [3:0] prod_op;
        logic       acc_load;
        logic       st_en;
        logic [1:0] st_sel;
        logic       rd_en;
        logic [1:0] rd_curve;
        logic [1:0] rd_coef;
        logic       fs_en;
        logic       tot_en;
        logic       clr_tot;
        logic       wr_en;
    } stpef_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       kept;
        logic       load_ok;
    } stpef_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -68'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        if (x > 49'sd140737488355327)
            return 48'sh7fffffffffff;
        else if (x < -49'sd140737488355328)
            return 48'sh800000000000;
        else
            return x[47:0];
    endfunction

endpackage

### src/stpef_in_if.sv
// ---------------------------------------------------------------------------
// stpef_in_if
// Pair item channel: valid, ready and the input item.
// ---------------------------------------------------------------------------
interface stpef_in_if import stpef_pkg::*;;
    logic      valid;
    logic      ready;
    stpef_in_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### src/stpef_out_if.sv
// ---------------------------------------------------------------------------
// stpef_out_if
// Result item channel: valid, ready and the result item.
// ---------------------------------------------------------------------------
interface stpef_out_if import stpef_pkg::*;;
    logic       valid;
    logic       ready;
    stpef_out_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### src/stpef_cfg.sv
// ---------------------------------------------------------------------------
// stpef_cfg
// APB register file for cutoff and knot spacing values.
// ---------------------------------------------------------------------------
module stpef_cfg import stpef_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output stpef_cfg_t        cfg
);

    logic [30:0] cutoff_reg;
    logic [30:0] knot_sp_reg;
    logic [30:0] inv_knot_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg   <= CUTOFF_RST;
            knot_sp_reg  <= KNOT_SP_RST;
            inv_knot_reg <= INV_KNOT_RST;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_CUTOFF:   cutoff_reg   <= pwdata[30:0];
                REG_KNOT_SP:  knot_sp_reg  <= pwdata[30:0];
                REG_INV_KNOT: inv_knot_reg <= pwdata[30:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CUTOFF:   prdata = {1'b0, cutoff_reg};
            REG_KNOT_SP:  prdata = {1'b0, knot_sp_reg};
            REG_INV_KNOT: prdata = {1'b0, inv_knot_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.cutoff           = cutoff_reg;
    assign cfg.knot_spacing     = knot_sp_reg;
    assign cfg.inv_knot_spacing = inv_knot_reg;

endmodule

### src/stpef_dp.sv
// ---------------------------------------------------------------------------
// stpef_dp
// Datapath: spline table, shared multiplier, Horner accumulator, totals.
// ---------------------------------------------------------------------------
module stpef_dp import stpef_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF,
    parameter int NUM_KNOTS = NUM_KNOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stpef_in_t   in_item,
    input  stpef_cfg_t  cfg,
    input  stpef_cmd_t  cmd,
    output stpef_stat_t stat,
    output stpef_out_t  out_item
);

    localparam int PAIR_WORDS = NUM_KNOTS * 16;
    localparam int TBL_WORDS  = NUM_TYPES * NUM_TYPES * PAIR_WORDS;
    localparam int AW         = $clog2(TBL_WORDS);
    localparam int KW         = $clog2(NUM_KNOTS);

    logic [31:0]        mem [TBL_WORDS];
    logic [31:0]        rdata_reg;

    stpef_in_t          it_reg;
    logic               kept_reg;
    logic signed [31:0] ev_reg, ee_reg, cv_reg, cc_reg, fs_reg;
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic signed [31:0] acc_reg, dif_reg, qq_reg;
    logic [KW-1:0]      r_reg;
    logic [KW-1:0]      r_next;
    logic signed [65:0] prod_reg;
    logic signed [47:0] vdw_reg, ele_reg;

    logic [1:0]         tmin, tmax;
    logic               types_ok;
    logic [31:0]        pair_idx;
    logic [AW-1:0]      pair_base;
    logic [AW-1:0]      raddr, waddr;
    logic               load_ok;
    logic               near_z, near_y, kept_c;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod_sh;
    logic signed [67:0] d_ext;
    logic signed [31:0] coef;
    logic [29:0]        quo;

    // pair selection
    assign tmin     = (it_reg.type_i < it_reg.type_j) ? it_reg.type_i : it_reg.type_j;
    assign tmax     = (it_reg.type_i < it_reg.type_j) ? it_reg.type_j : it_reg.type_i;
    assign types_ok = 5'(tmax) < 5'(NUM_TYPES);
    assign pair_idx = 32'(tmin) * 32'(NUM_TYPES) + 32'(tmax);
    assign pair_base = AW'(pair_idx * 32'(PAIR_WORDS));
    assign load_ok  = types_ok && (it_reg.owner_id < 32'(PAIR_WORDS));
    assign waddr    = pair_base + AW'(it_reg.owner_id[KW+3:0]);
    assign raddr    = pair_base + AW'({r_reg, cmd.rd_curve, cmd.rd_coef});

    // half-list filter
    assign near_z = (it_reg.disp_z < SMALL_Q) && (it_reg.disp_z > -SMALL_Q);
    assign near_y = (it_reg.disp_y < SMALL_Q) && (it_reg.disp_y > -SMALL_Q);
    assign kept_c = types_ok && (it_reg.dist_req <= cfg.cutoff) &&
                    (it_reg.partner_local ||
                     (it_reg.owner_id < it_reg.partner_id) ||
                     ((it_reg.owner_id == it_reg.partner_id) &&
                      ((it_reg.disp_z > SMALL_Q) ||
                       (near_z && ((it_reg.disp_y > SMALL_Q) ||
                                   (near_y && (it_reg.disp_x > SMALL_Q)))))));

    assign stat.mode    = it_reg.mode;
    assign stat.kept    = kept_c;
    assign stat.load_ok = load_ok;

    assign prod_sh = prod_reg >>> 16;
    assign d_ext   = $signed({37'd0, it_reg.dist_req});
    assign coef    = $signed(rdata_reg);
    assign quo     = prod_reg[61:32];

    // knot index: raise zero to one, saturate at the top knot
    always_comb
    begin
        if (quo == 30'd0)
            r_next = KW'(1);
        else if (quo > 30'(NUM_KNOTS - 1))
            r_next = KW'(NUM_KNOTS - 1);
        else
            r_next = quo[KW-1:0];
    end

    always_comb
    begin
        case (cmd.mul_sel)
            M_DINV:
            begin
                op_a = $signed({2'b00, it_reg.dist_req});
                op_b = $signed({2'b00, cfg.inv_knot_spacing});
            end
            M_KS:
            begin
                op_a = $signed(33'(r_reg) + 33'd1);
                op_b = $signed({2'b00, cfg.knot_spacing});
            end
            M_QQ:
            begin
                op_a = 33'(it_reg.charge_i);
                op_b = 33'(it_reg.charge_j);
            end
            M_HORN:
            begin
                op_a = 33'(acc_reg);
                op_b = 33'(dif_reg);
            end
            M_EE:
            begin
                op_a = 33'(ee_reg);
                op_b = 33'(qq_reg);
            end
            M_CC:
            begin
                op_a = 33'(cc_reg);
                op_b = 33'(qq_reg);
            end
            M_FX:
            begin
                op_a = 33'(fs_reg);
                op_b = 33'(it_reg.disp_x);
            end
            M_FY:
            begin
                op_a = 33'(fs_reg);
                op_b = 33'(it_reg.disp_y);
            end
            M_FZ:
            begin
                op_a = 33'(fs_reg);
                op_b = 33'(it_reg.disp_z);
            end
            default:
            begin
                op_a = 33'sd0;
                op_b = 33'sd0;
            end
        endcase
    end

    // table: one write or one read a cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[waddr] <= it_reg.charge_i;
        if (cmd.rd_en)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            it_reg <= in_item;
        if (cmd.mul_sel != M_NONE)
            prod_reg <= op_a * op_b;
        if (cmd.prod_op == P_R)
            r_reg <= r_next;
        if (cmd.prod_op == P_DIF)
            dif_reg <= sat32(d_ext - 68'(prod_reg));
        if (cmd.prod_op == P_QQ)
            qq_reg <= sat32(68'(prod_sh));
        if (cmd.acc_load)
            acc_reg <= coef;
        else if (cmd.prod_op == P_HORN)
            acc_reg <= sat32(68'(prod_sh) + 68'(coef));
    end

    // result registers, cleared as each item enters
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kept_reg <= 1'b0;
            ev_reg   <= '0;
            ee_reg   <= '0;
            cv_reg   <= '0;
            cc_reg   <= '0;
            fs_reg   <= '0;
            fx_reg   <= '0;
            fy_reg   <= '0;
            fz_reg   <= '0;
        end
        else
        begin
            if (cmd.set_kept)
                kept_reg <= 1'b1;
            if (cmd.st_en)
            begin
                case (cmd.st_sel)
                    2'd0:    ev_reg <= acc_reg;
                    2'd1:    ee_reg <= acc_reg;
                    2'd2:    cv_reg <= acc_reg;
                    default: cc_reg <= acc_reg;
                endcase
            end
            if (cmd.prod_op == P_EE)
                ee_reg <= sat32(68'(prod_sh));
            if (cmd.prod_op == P_CC)
                cc_reg <= sat32(68'(prod_sh));
            if (cmd.fs_en)
                fs_reg <= sat32(68'(cv_reg) + 68'(cc_reg));
            if (cmd.prod_op == P_FX)
                fx_reg <= sat32(-68'(prod_sh));
            if (cmd.prod_op == P_FY)
                fy_reg <= sat32(-68'(prod_sh));
            if (cmd.prod_op == P_FZ)
                fz_reg <= sat32(-68'(prod_sh));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vdw_reg <= '0;
            ele_reg <= '0;
        end
        else if (cmd.clr_tot)
        begin
            vdw_reg <= '0;
            ele_reg <= '0;
        end
        else if (cmd.tot_en)
        begin
            vdw_reg <= sat48(49'(vdw_reg) + 49'(ev_reg));
            ele_reg <= sat48(49'(ele_reg) + 49'(ee_reg));
        end
    end

    assign out_item.pair_kept   = kept_reg;
    assign out_item.vdw_energy  = ev_reg;
    assign out_item.ele_energy  = ee_reg;
    assign out_item.force_scale = fs_reg;
    assign out_item.force_x     = fx_reg;
    assign out_item.force_y     = fy_reg;
    assign out_item.force_z     = fz_reg;
    assign out_item.total_vdw   = vdw_reg;
    assign out_item.total_ele   = ele_reg;

endmodule

### src/stpef_ctrl.sv
// ---------------------------------------------------------------------------
// stpef_ctrl
// Sequencer: steps one item through decode, Horner passes and force scaling.
// ---------------------------------------------------------------------------
`include "spline_table_pair_energy_force_defines.svh"

module stpef_ctrl import stpef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  stpef_stat_t stat,
    output stpef_cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_DECODE = 5'd1;
    localparam logic [4:0] ST_R      = 5'd2;
    localparam logic [4:0] ST_KS     = 5'd3;
    localparam logic [4:0] ST_DIF    = 5'd4;
    localparam logic [4:0] ST_LOAD   = 5'd5;
    localparam logic [4:0] ST_MUL    = 5'd6;
    localparam logic [4:0] ST_ADD    = 5'd7;
    localparam logic [4:0] ST_SCE    = 5'd8;
    localparam logic [4:0] ST_SCC    = 5'd9;
    localparam logic [4:0] ST_FSC    = 5'd10;
    localparam logic [4:0] ST_FSUM   = 5'd11;
    localparam logic [4:0] ST_FX     = 5'd12;
    localparam logic [4:0] ST_FY     = 5'd13;
    localparam logic [4:0] ST_FZ     = 5'd14;
    localparam logic [4:0] ST_FW     = 5'd15;
    localparam logic [4:0] ST_DONE   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [1:0] curve_reg, curve_next;
    logic [1:0] coef_reg, coef_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        curve_next = curve_reg;
        coef_next  = coef_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.mul_sel = M_DINV;
                state_next  = ST_DONE;
                case (stat.mode)
                    MODE_LOAD:  cmd.wr_en   = stat.load_ok;
                    MODE_CLEAR: cmd.clr_tot = 1'b1;
                    MODE_EVAL:
                    begin
                        if (stat.kept)
                        begin
                            cmd.set_kept = 1'b1;
                            state_next   = ST_R;
                        end
                    end
                    default:    ;
                endcase
            end
            ST_R:
            begin
                cmd.prod_op = P_R;
                cmd.mul_sel = M_QQ;
                state_next  = ST_KS;
            end
            ST_KS:
            begin
                cmd.prod_op = P_QQ;
                cmd.mul_sel = M_KS;
                state_next  = ST_DIF;
            end
            ST_DIF:
            begin
                cmd.prod_op  = P_DIF;
                cmd.rd_en    = 1'b1;
                cmd.rd_curve = 2'd0;
                cmd.rd_coef  = 2'd3;
                curve_next   = 2'd0;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                // start a curve from its cube term; park the previous curve
                cmd.acc_load = 1'b1;
                cmd.st_en    = (curve_reg != 2'd0);
                cmd.st_sel   = curve_reg - 2'd1;
                cmd.rd_en    = 1'b1;
                cmd.rd_curve = curve_reg;
                cmd.rd_coef  = 2'd2;
                coef_next    = 2'd2;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_sel = M_HORN;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.prod_op = P_HORN;
                if (coef_reg != 2'd0)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_curve = curve_reg;
                    cmd.rd_coef  = coef_reg - 2'd1;
                    coef_next    = coef_reg - 2'd1;
                    state_next   = ST_MUL;
                end
                else if (curve_reg != 2'd3)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_curve = curve_reg + 2'd1;
                    cmd.rd_coef  = 2'd3;
                    curve_next   = curve_reg + 2'd1;
                    state_next   = ST_LOAD;
                end
                else
                begin
                    state_next = ST_SCE;
                end
            end
            ST_SCE:
            begin
                cmd.st_en   = 1'b1;
                cmd.st_sel  = 2'd3;
                cmd.mul_sel = M_EE;
                state_next  = ST_SCC;
            end
            ST_SCC:
            begin
                cmd.prod_op = P_EE;
                cmd.mul_sel = M_CC;
                state_next  = ST_FSC;
            end
            ST_FSC:
            begin
                cmd.prod_op = P_CC;
                state_next  = ST_FSUM;
            end
            ST_FSUM:
            begin
                cmd.fs_en  = 1'b1;
                state_next = ST_FX;
            end
            ST_FX:
            begin
                cmd.mul_sel = M_FX;
                state_next  = ST_FY;
            end
            ST_FY:
            begin
                cmd.prod_op = P_FX;
                cmd.mul_sel = M_FY;
                state_next  = ST_FZ;
            end
            ST_FZ:
            begin
                cmd.prod_op = P_FY;
                cmd.mul_sel = M_FZ;
                state_next  = ST_FW;
            end
            ST_FW:
            begin
                cmd.prod_op = P_FZ;
                cmd.tot_en  = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            curve_reg <= 2'd0;
            coef_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            curve_reg <= curve_next;
            coef_reg  <= coef_next;
        end
    end

    `STPEF_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_reg == ST_DECODE, "accepted item skipped decode")
    `STPEF_ASSERT_NEXT(a_mul_then_add, state_reg == ST_MUL, state_reg == ST_ADD, "Horner multiply not followed by add")
    `STPEF_ASSERT_NEXT(a_last_curve, state_reg == ST_ADD && coef_reg == 2'd0 && curve_reg == 2'd3, state_reg == ST_SCE, "fourth curve did not end Horner passes")
    `STPEF_ASSERT_NOW(a_side_effects, 1'b1, $onehot0({cmd.wr_en, cmd.clr_tot, cmd.tot_en}), "conflicting table or total updates")

endmodule

### src/spline_table_pair_energy_force.sv
// ---------------------------------------------------------------------------
// spline_table_pair_energy_force
// Tabulated cubic spline pair energy and force evaluator, Q16.16.
// ---------------------------------------------------------------------------
//  channel     kind          direction  carries
//  pair_in     valid/ready   in         stpef_in_t: mode, types, distance, ids
//  result_out  valid/ready   out        stpef_out_t: energies, forces, totals
//  apb         psel/penable  in/out     cutoff, knot_spacing, inv_knot_spacing
//
//  An evaluated pair that passes the filter uses one 33x33 multiplier,
//  shared by the knot index, the knot offset, the charge product, 12 Horner
//  steps (multiply then add), two charge scalings and three force products.
//  Table loads, clears, no-op items and dropped pairs go from decode straight
//  to the result. One item is in flight; the result is held until result_out
//  is taken. Reset clears the sequencer, the totals and the configuration
//  registers; the table keeps whatever was last written and needs no
//  clearing pass.
// ---------------------------------------------------------------------------
module spline_table_pair_energy_force import stpef_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF,
    parameter int NUM_KNOTS = NUM_KNOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    stpef_in_if.sink          pair_in,
    stpef_out_if.source       result_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    stpef_cfg_t  cfg;
    stpef_cmd_t  cmd;
    stpef_stat_t stat;

    // register file: to be written between items only; the block does not enforce it
    stpef_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns both handshakes, issues one command word per cycle
    stpef_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair_in.valid),
        .in_ready  (pair_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: table memory, multiplier, accumulators, result registers
    stpef_dp #(
        .NUM_TYPES (NUM_TYPES),
        .NUM_KNOTS (NUM_KNOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (pair_in.item),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (result_out.item)
    );

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spline pair energy and force block. Loads
// spline tables over the pair channel, evaluates pairs against a local
// Q16.16 predictor and compares every result item as a whole.
// ---------------------------------------------------------------------------
module tb_top;
    import stpef_pkg::*;

    localparam int NTYPES = NUM_TYPES_DEF;
    localparam int NKNOTS = NUM_KNOTS_DEF;
    localparam int PAIR_WORDS = NKNOTS * 16;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    stpef_in_if  pair_ch ();
    stpef_out_if res_ch ();

    spline_table_pair_energy_force dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_in    (pair_ch.sink),
        .result_out (res_ch.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock: period 4
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    logic [31:0] coef_mem [int];
    logic signed [47:0] vdw_total;
    logic signed [47:0] ele_total;
    stpef_cfg_t cfg;

    stpef_out_t result_q [$];
    int mismatches;
    int idle_pct;
    bit timed_out;

    // loaded knots, per type pair and knot, so evaluations only hit loaded knots
    bit knot_loaded [NTYPES*NTYPES][NKNOTS];

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint fl16(input longint x);
        return x >>> 16;
    endfunction

    function automatic logic signed [31:0] qprod(input longint a, input longint b);
        return clamp32(fl16(a * b));
    endfunction

    function automatic logic signed [31:0] horner(input int base, input longint dif);
        longint acc;
        acc = longint'($signed(coef_mem[base + 3]));
        for (int k = 2; k >= 0; k--)
            acc = longint'(clamp32(fl16(acc * dif) + longint'($signed(coef_mem[base + k]))));
        return acc[31:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input longint x);
        if (x > 64'sd140737488355327)
            return 48'sh7fffffffffff;
        if (x < -64'sd140737488355328)
            return 48'sh800000000000;
        return x[47:0];
    endfunction

    function automatic longint absl(input longint x);
        return x < 0 ? -x : x;
    endfunction

    // compute the result of one pair item and advance the energy totals
    function automatic stpef_out_t predict_pair(input stpef_in_t it);
        stpef_out_t r;
        logic [1:0] tmin;
        logic [1:0] tmax;
        int pbase;
        bit kept;
        longint dz;
        longint dy;
        longint dx;
        longint knot;
        longint dif;
        longint qq;
        longint cv;
        longint cc;
        longint fs;
        int kb;
        r = '0;
        kept = 0;
        tmin = it.type_i < it.type_j ? it.type_i : it.type_j;
        tmax = it.type_i < it.type_j ? it.type_j : it.type_i;
        pbase = (tmin * NTYPES + tmax) * PAIR_WORDS;
        dx = longint'(it.disp_x);
        dy = longint'(it.disp_y);
        dz = longint'(it.disp_z);
        if (it.mode == MODE_LOAD) begin
            if (it.owner_id < PAIR_WORDS)
                coef_mem[pbase + int'(it.owner_id)] = it.charge_i;
        end
        else if (it.mode == MODE_CLEAR) begin
            vdw_total = '0;
            ele_total = '0;
        end
        else if (it.mode == MODE_EVAL && it.dist_req <= cfg.cutoff) begin
            // half-list filter: local partner, higher id, or tie broken by z, y, x
            if (it.partner_local)
                kept = 1;
            else if (it.owner_id < it.partner_id)
                kept = 1;
            else if (it.owner_id == it.partner_id) begin
                if (dz > SMALL_Q)
                    kept = 1;
                else if (absl(dz) < SMALL_Q) begin
                    if (dy > SMALL_Q)
                        kept = 1;
                    else if (absl(dy) < SMALL_Q && dx > SMALL_Q)
                        kept = 1;
                end
            end
            if (kept) begin
                knot = longint'((64'(it.dist_req) * 64'(cfg.inv_knot_spacing)) >> 32);
                if (knot == 0)
                    knot = 1;
                if (knot > NKNOTS - 1)
                    knot = NKNOTS - 1;
                dif = longint'(clamp32(longint'(it.dist_req)
                    - (knot + 1) * longint'(cfg.knot_spacing)));
                kb = pbase + int'(knot) * 16;
                qq = longint'(qprod(longint'(it.charge_i), longint'(it.charge_j)));
                r.vdw_energy = horner(kb, dif);
                r.ele_energy = qprod(longint'(horner(kb + 4, dif)), qq);
                cv = longint'(horner(kb + 8, dif));
                cc = longint'(qprod(longint'(horner(kb + 12, dif)), qq));
                fs = longint'(clamp32(cv + cc));
                r.force_scale = fs[31:0];
                r.force_x = clamp32(-fl16(fs * dx));
                r.force_y = clamp32(-fl16(fs * dy));
                r.force_z = clamp32(-fl16(fs * dz));
                vdw_total = clamp48(longint'(vdw_total) + longint'(r.vdw_energy));
                ele_total = clamp48(longint'(ele_total) + longint'(r.ele_energy));
            end
        end
        r.pair_kept = kept;
        r.total_vdw = vdw_total;
        r.total_ele = ele_total;
        return r;
    endfunction

    // drive one item at the falling edge and hold it until accepted
    task automatic send_item(input stpef_in_t it);
        @(negedge clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            @(negedge clk);
        pair_ch.valid <= 1'b1;
        pair_ch.item  <= it;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        result_q.push_back(predict_pair(it));
        @(negedge clk);
        pair_ch.valid <= 1'b0;
    endtask

    // drain: wait for every expected result, then let a dropped item finish
    task automatic wait_drained();
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // a setup phase, then an access phase; the caller returns the port to idle
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= {1'b0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            REG_CUTOFF:  cfg.cutoff = val;
            REG_KNOT_SP: cfg.knot_spacing = val;
            default:     cfg.inv_knot_spacing = val;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // load all 16 words of one knot for one type pair
    task automatic load_knot(input int ti, input int tj, input int knot, input bit wild);
        stpef_in_t it;
        int pidx;
        for (int w = 0; w < 16; w++) begin
            it = '0;
            it.mode = MODE_LOAD;
            it.type_i = 2'(ti);
            it.type_j = 2'(tj);
            it.owner_id = knot * 16 + w;
            it.charge_i = wild ? rand_word() : 32'($signed($urandom_range(131072)) - 65536);
            it.dist_req = 31'($urandom);
            it.partner_id = $urandom;
            send_item(it);
        end
        pidx = (ti < tj ? ti : tj) * NTYPES + (ti < tj ? tj : ti);
        knot_loaded[pidx][knot] = 1;
    endtask

    // knot index the block will pick for a distance under the current setting
    function automatic int knot_of(input logic [30:0] d);
        longint k;
        k = longint'((64'(d) * 64'(cfg.inv_knot_spacing)) >> 32);
        if (k == 0)
            k = 1;
        if (k > NKNOTS - 1)
            k = NKNOTS - 1;
        return int'(k);
    endfunction

    // random pair; loads the knot first if the pair is within the cutoff and the knot was never loaded
    task automatic eval_pair(input logic [30:0] d, input bit rand_fields);
        stpef_in_t it;
        int pidx;
        int kn;
        it = '0;
        it.mode = MODE_EVAL;
        it.type_i = 2'($urandom_range(3));
        it.type_j = 2'($urandom_range(3));
        it.dist_req = d;
        it.charge_i = rand_word();
        it.charge_j = rand_word();
        it.disp_x = rand_word();
        it.disp_y = rand_word();
        it.disp_z = rand_word();
        it.partner_local = 1'($urandom_range(1));
        it.owner_id = $urandom;
        it.partner_id = $urandom_range(1) ? it.owner_id : $urandom;
        if (!rand_fields) begin
            // near-threshold tie cases
            it.partner_local = 0;
            it.partner_id = it.owner_id;
            it.disp_x = $urandom_range(16) - 8;
            it.disp_y = $urandom_range(16) - 8;
            it.disp_z = $urandom_range(16) - 8;
        end
        pidx = (it.type_i < it.type_j ? it.type_i : it.type_j) * NTYPES
            + (it.type_i < it.type_j ? it.type_j : it.type_i);
        kn = knot_of(d);
        // a kept pair reads its knot, so make sure the knot is loaded
        if (d <= cfg.cutoff && !knot_loaded[pidx][kn])
            load_knot(it.type_i, it.type_j, kn, $urandom_range(3) == 0);
        send_item(it);
    endtask

    // first distance whose raw knot index reaches k
    function automatic longint knot_start(input int k);
        return (longint'(k) * 64'sd4294967296 + longint'(cfg.inv_knot_spacing) - 1)
            / longint'(cfg.inv_knot_spacing);
    endfunction

    // distance aimed at a small pool of knots, so few knots need loading
    function automatic logic [30:0] rand_dist();
        longint lo;
        longint hi;
        longint lim;
        int k;
        if ($urandom_range(9) == 0)
            return 31'($urandom);
        case ($urandom_range(2))
            0:       k = 1;
            1:       k = 2;
            default: k = NKNOTS - 1;
        endcase
        lo = (k == 1) ? 64'sd0 : knot_start(k);
        if (lo > 64'sd2147483647) begin
            k = 1;
            lo = 0;
        end
        if (k == NKNOTS - 1)
            hi = 64'sd2147483647;
        else
            hi = knot_start(k + 1) - 1;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        // keep most of the range near the cutoff, with a little beyond it
        lim = longint'(cfg.cutoff) + 4096;
        if (lim < lo)
            lim = lo;
        if (hi > lim)
            hi = lim;
        return 31'(lo + longint'($urandom_range(32'(hi - lo))));
    endfunction

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    task automatic test_directed();
        stpef_in_t it;
        // loads with out-of-range address are ignored; clears; mode 3 no-op
        load_knot(0, 0, 1, 1);
        load_knot(3, 3, NKNOTS - 1, 1);
        it = '0;
        it.mode = MODE_LOAD;
        it.owner_id = 32'hffffffff;
        it.charge_i = 32'h12345678;
        send_item(it);
        it.owner_id = PAIR_WORDS;
        send_item(it);
        // zero distance clamps the knot to 1; top distance saturates
        eval_pair('0, 1);
        eval_pair(cfg.cutoff, 1);
        eval_pair(cfg.cutoff + 31'd1, 1);
        eval_pair(31'h7fffffff, 1);
        eval_pair(31'd1000, 0);
        eval_pair(31'd1000, 0);
        it = '0;
        it.mode = MODE_NONE;
        send_item(it);
        it.mode = MODE_CLEAR;
        send_item(it);
    endtask

    task automatic test_random(input int count);
        stpef_in_t it;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(19))
                0: begin
                    it = '0;
                    it.mode = $urandom_range(1) ? MODE_CLEAR : MODE_NONE;
                    it.dist_req = 31'($urandom);
                    send_item(it);
                end
                1: begin
                    // stray load of a random word to an out-of-range address
                    it = '0;
                    it.mode = MODE_LOAD;
                    it.owner_id = $urandom;
                    if (it.owner_id < PAIR_WORDS)
                        it.owner_id = it.owner_id | 32'h8000_0000;
                    it.charge_i = $urandom;
                    send_item(it);
                end
                2, 3: eval_pair(rand_dist(), 0);
                default: eval_pair(rand_dist(), 1);
            endcase
        end
    endtask

    task automatic test_config(input logic [30:0] co, input logic [30:0] ks,
                               input logic [30:0] iks, input int count);
        wait_drained();
        write_reg(REG_CUTOFF, co);
        write_reg(REG_KNOT_SP, ks);
        write_reg(REG_INV_KNOT, iks);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        test_random(count);
    endtask

    // -----------------------------------------------------------------------
    // result checker: sample on the rising edge
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        stpef_out_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res_ch.item);
            end
            else begin
                want = result_q.pop_front();
                if (want !== res_ch.item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, res_ch.item);
                end
            end
        end
    end

    // sink stall, changed at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
    end

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pair_ch.valid = 1'b0;
        pair_ch.item = '0;
        res_ch.ready = 1'b0;
        mismatches = 0;
        idle_pct = 37;
        vdw_total = '0;
        ele_total = '0;
        cfg.cutoff = CUTOFF_RST;
        cfg.knot_spacing = KNOT_SP_RST;
        cfg.inv_knot_spacing = INV_KNOT_RST;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(260);
        // hold the sender until everything has come back
        wait_drained();
        // long stretch with no idling on either side
        idle_pct = 0;
        test_random(100);
        idle_pct = 37;
        test_config(31'h7fffffff, 31'd1, 31'd1, 130);
        test_config(31'd0, 31'h7fffffff, 31'h7fffffff, 80);
        test_config(31'd2000000, 31'd8192, 31'd2097152, 240);
        test_config(31'd4000000, 31'd65536, 31'd65536, 200);
        test_config(CUTOFF_RST, KNOT_SP_RST, INV_KNOT_RST, 200);

        wait_drained();
        if (mismatches == 0 && result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
